>>> src/dft_pkg.sv
// Shared types and codes for the programmable transducer block.
// No dependencies; imported by dft_match and dfa_transducer_step.
package dft_pkg;

    localparam int SYM_W       = 8;
    localparam int STATE_W     = 5;
    localparam int LEN_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int CHAR_FIELDS = 4;
    localparam int ENTRY_HDR_W = SYM_W + STATE_W + LEN_W;

    localparam logic [1:0] ACT_ADD_STATE = 2'd0;
    localparam logic [1:0] ACT_ADD_TRANS = 2'd1;
    localparam logic [1:0] ACT_SYMBOL    = 2'd2;
    localparam logic [1:0] ACT_END_WORD  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef logic [SYM_W-1:0] char_t;

    typedef struct packed {
        logic clear;
        logic check;
    } scan_ctrl_t;

endpackage

>>> src/dft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/dft_match.sv
// Shared trigger comparator: checks one stored transition per cycle and keeps the last hit.
// Depends on dft_pkg.
module dft_match
    import dft_pkg::*;
#(
    parameter int KEPT = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  scan_ctrl_t                         ctrl,
    input  char_t                              symbol,
    input  logic [ENTRY_HDR_W+SYM_W*KEPT-1:0]  entry,
    output logic                               hit_valid,
    output logic [ENTRY_HDR_W+SYM_W*KEPT-1:0]  hit_entry
);

    localparam int TEW = ENTRY_HDR_W + SYM_W * KEPT;

    logic           hit_valid_reg;
    logic [TEW-1:0] hit_entry_reg;
    logic           trig_eq;

    // trigger sits in the top byte of an entry
    assign trig_eq = (entry[TEW-1 -: SYM_W] == symbol);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            hit_valid_reg <= 1'b0;
        end
        else if (ctrl.check && trig_eq)
        begin
            hit_valid_reg <= 1'b1;
        end
    end

    // later matches overwrite earlier ones
    always_ff @(posedge clk)
    begin
        if (ctrl.check && trig_eq)
        begin
            hit_entry_reg <= entry;
        end
    end

    assign hit_valid = hit_valid_reg;
    assign hit_entry = hit_entry_reg;

endmodule

>>> src/dfa_transducer_step.sv
// Top level of the programmable deterministic Mealy transducer.
// Depends on dft_pkg, dft_ram and dft_match.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  input   | in_valid/in_stall  | action symbol final_flag source_state
//          |                    | dest_state out_len out_char0..3
//  output  | out_valid/out_stall| status matched trans_len trans_char0..3
//          |                    | current_state accepted
//
// Sequence: one transaction at a time. Add-state, add-transition, end-of-word and a
// symbol whose present state holds no transitions (or was never added) pass through
// lookup, evaluate and done; any other symbol also scans the transitions stored for
// the present state (up to MAX_TRANS), paced by the one-read-per-cycle port of the
// transition RAM feeding the comparator. The input is free again in the same cycle
// that the result appears in the output register.
// Reset: state count and present state clear to zero; the RAMs need no clearing,
// a state's entry in the state RAM is always written (with no transitions) when it is added.
// Stalls: the result waits in the output register; the next transaction is taken
// meanwhile and held at its last step until the output register frees up.
module dfa_transducer_step
    import dft_pkg::*;
#(
    parameter int MAX_STATES = 32,
    parameter int MAX_TRANS  = 16,
    parameter int OUT_CHARS  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [SYM_W-1:0]    symbol,
    input  logic                final_flag,
    input  logic [STATE_W-1:0]  source_state,
    input  logic [STATE_W-1:0]  dest_state,
    input  logic [LEN_W-1:0]    out_len,
    input  logic [SYM_W-1:0]    out_char0,
    input  logic [SYM_W-1:0]    out_char1,
    input  logic [SYM_W-1:0]    out_char2,
    input  logic [SYM_W-1:0]    out_char3,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                matched,
    output logic [LEN_W-1:0]    trans_len,
    output logic [SYM_W-1:0]    trans_char0,
    output logic [SYM_W-1:0]    trans_char1,
    output logic [SYM_W-1:0]    trans_char2,
    output logic [SYM_W-1:0]    trans_char3,
    output logic [STATE_W-1:0]  current_state,
    output logic                accepted
);

    // characters actually kept per transition
    localparam int KEPT    = (OUT_CHARS < CHAR_FIELDS) ? OUT_CHARS : CHAR_FIELDS;
    localparam int TEW     = ENTRY_HDR_W + SYM_W * KEPT;
    localparam int SIDX_W  = $clog2(MAX_STATES);
    localparam int SCNT_W  = $clog2(MAX_STATES + 1);
    localparam int TCNT_W  = $clog2(MAX_TRANS + 1);
    localparam int TIDX_W  = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
    localparam int TDEPTH  = MAX_STATES * MAX_TRANS;
    localparam int TADDR_W = $clog2(TDEPTH);
    localparam int CMP_W   = (SCNT_W > STATE_W) ? SCNT_W : STATE_W;
    localparam int SRW     = TCNT_W + 1;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [SCNT_W-1:0]   state_count_reg, state_count_next;
    logic [STATE_W-1:0]  present_state_reg, present_state_next;
    logic [TCNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [TCNT_W-1:0]   n_reg, n_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_accepted_reg, res_accepted_next;

    // latched transaction
    logic [1:0]          act_reg;
    logic [SYM_W-1:0]    sym_reg;
    logic                fin_reg;
    logic [STATE_W-1:0]  src_reg;
    logic [STATE_W-1:0]  dst_reg;
    logic [LEN_W-1:0]    len_reg;
    char_t               char_reg [CHAR_FIELDS];

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic                matched_reg;
    logic [LEN_W-1:0]    trans_len_reg;
    char_t               trans_char_reg [CHAR_FIELDS];
    logic [STATE_W-1:0]  current_state_reg;
    logic                accepted_reg;

    // RAM ports
    logic                srd_we;
    logic [SIDX_W-1:0]   srd_waddr, srd_raddr;
    logic [SRW-1:0]      srd_wdata, srd_rdata;
    logic                srd_flag;
    logic [TCNT_W-1:0]   srd_cnt;
    logic                tr_we;
    logic [TADDR_W-1:0]  tr_waddr, tr_raddr;
    logic [TEW-1:0]      tr_wdata, tr_rdata;

    // comparator
    scan_ctrl_t          scan_ctrl;
    logic                hit_valid;
    logic [TEW-1:0]      hit_entry;
    char_t               hit_char [CHAR_FIELDS];
    logic                sym_hit;

    logic                accept;
    logic                fire;
    logic                issue;
    logic                src_ok, dst_ok, cur_ok;
    logic                states_full, trans_full;
    logic [LEN_W-1:0]    len_sat;
    logic [SYM_W*KEPT-1:0] wchars;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign fire     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign srd_flag = srd_rdata[TCNT_W];
    assign srd_cnt  = srd_rdata[TCNT_W-1:0];

    assign src_ok      = CMP_W'(src_reg) < CMP_W'(state_count_reg);
    assign dst_ok      = CMP_W'(dst_reg) < CMP_W'(MAX_STATES);
    assign cur_ok      = CMP_W'(present_state_reg) < CMP_W'(state_count_reg);
    assign states_full = (state_count_reg == SCNT_W'(MAX_STATES));
    assign trans_full  = (srd_cnt == TCNT_W'(MAX_TRANS));
    assign issue       = (scan_idx_reg < n_reg);

    // clamp the translation length to what is kept
    assign len_sat = (len_reg > LEN_W'(KEPT)) ? LEN_W'(KEPT) : len_reg;

    // zero characters at or beyond the clamped length
    for (genvar i = 0; i < KEPT; i++)
    begin : g_wchar
        assign wchars[SYM_W*i +: SYM_W] = (LEN_W'(i) < len_sat) ? char_reg[i] : '0;
    end

    for (genvar i = 0; i < CHAR_FIELDS; i++)
    begin : g_hchar
        if (i < KEPT)
        begin : g_kept
            assign hit_char[i] = hit_entry[SYM_W*i +: SYM_W];
        end
        else
        begin : g_zero
            assign hit_char[i] = '0;
        end
    end

    assign sym_hit = (act_reg == ACT_SYMBOL) && hit_valid;

    // state RAM: read the source on add-transition, the present state otherwise
    assign srd_raddr = (act_reg == ACT_ADD_TRANS) ? SIDX_W'(src_reg)
                                                  : SIDX_W'(present_state_reg);

    assign tr_raddr = TADDR_W'(TADDR_W'(SIDX_W'(present_state_reg)) * TADDR_W'(MAX_TRANS)
                               + TADDR_W'(TIDX_W'(scan_idx_reg)));
    assign tr_waddr = TADDR_W'(TADDR_W'(SIDX_W'(src_reg)) * TADDR_W'(MAX_TRANS)
                               + TADDR_W'(TIDX_W'(srd_cnt)));
    assign tr_wdata = {sym_reg, dst_reg, len_sat, wchars};

    always_comb
    begin
        state_next         = state_reg;
        state_count_next   = state_count_reg;
        present_state_next = present_state_reg;
        scan_idx_next      = scan_idx_reg;
        n_next             = n_reg;
        rd_pend_next       = 1'b0;
        res_status_next    = res_status_reg;
        res_accepted_next  = res_accepted_reg;
        srd_we             = 1'b0;
        srd_waddr          = SIDX_W'(state_count_reg);
        srd_wdata          = {fin_reg, TCNT_W'(0)};
        tr_we              = 1'b0;
        scan_ctrl          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                // state RAM read in flight
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                scan_ctrl.clear   = 1'b1;
                res_status_next   = ST_OK;
                res_accepted_next = 1'b0;
                state_next        = S_DONE;
                unique case (act_reg)
                    ACT_ADD_STATE:
                    begin
                        if (states_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            srd_we           = 1'b1;
                            state_count_next = state_count_reg + SCNT_W'(1);
                        end
                    end
                    ACT_ADD_TRANS:
                    begin
                        if (!src_ok || !dst_ok)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else if (trans_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            tr_we     = 1'b1;
                            srd_we    = 1'b1;
                            srd_waddr = SIDX_W'(src_reg);
                            srd_wdata = {srd_flag, srd_cnt + TCNT_W'(1)};
                        end
                    end
                    ACT_SYMBOL:
                    begin
                        if (!cur_ok)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else if (srd_cnt != '0)
                        begin
                            n_next        = srd_cnt;
                            scan_idx_next = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    ACT_END_WORD:
                    begin
                        if (!cur_ok)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            res_accepted_next = srd_flag;
                        end
                        present_state_next = '0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // issue one read per cycle, compare the one that just returned
                scan_ctrl.check = rd_pend_reg;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + TCNT_W'(1);
                    rd_pend_next  = 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (fire)
                begin
                    if (sym_hit)
                    begin
                        present_state_next = hit_entry[TEW-SYM_W-1 -: STATE_W];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            state_count_reg   <= '0;
            present_state_reg <= '0;
            rd_pend_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            state_count_reg   <= state_count_next;
            present_state_reg <= present_state_next;
            rd_pend_reg       <= rd_pend_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        scan_idx_reg     <= scan_idx_next;
        n_reg            <= n_next;
        res_status_reg   <= res_status_next;
        res_accepted_reg <= res_accepted_next;
        if (accept)
        begin
            act_reg     <= action;
            sym_reg     <= symbol;
            fin_reg     <= final_flag;
            src_reg     <= source_state;
            dst_reg     <= dest_state;
            len_reg     <= out_len;
            char_reg[0] <= out_char0;
            char_reg[1] <= out_char1;
            char_reg[2] <= out_char2;
            char_reg[3] <= out_char3;
        end
        if (fire)
        begin
            status_reg        <= res_status_reg;
            matched_reg       <= sym_hit;
            trans_len_reg     <= sym_hit ? hit_entry[TEW-SYM_W-STATE_W-1 -: LEN_W] : '0;
            current_state_reg <= present_state_next;
            accepted_reg      <= res_accepted_reg;
            for (int i = 0; i < CHAR_FIELDS; i++)
            begin
                trans_char_reg[i] <= sym_hit ? hit_char[i] : '0;
            end
        end
    end

    dft_ram #(
        .WIDTH (SRW),
        .DEPTH (MAX_STATES)
    ) u_state_ram (
        .clk   (clk),
        .we    (srd_we),
        .waddr (srd_waddr),
        .wdata (srd_wdata),
        .raddr (srd_raddr),
        .rdata (srd_rdata)
    );

    dft_ram #(
        .WIDTH (TEW),
        .DEPTH (TDEPTH)
    ) u_trans_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    dft_match #(
        .KEPT (KEPT)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .symbol    (sym_reg),
        .entry     (tr_rdata),
        .hit_valid (hit_valid),
        .hit_entry (hit_entry)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign matched       = matched_reg;
    assign trans_len     = trans_len_reg;
    assign trans_char0   = trans_char_reg[0];
    assign trans_char1   = trans_char_reg[1];
    assign trans_char2   = trans_char_reg[2];
    assign trans_char3   = trans_char_reg[3];
    assign current_state = current_state_reg;
    assign accepted      = accepted_reg;

    // an accepted transaction always starts with the state RAM lookup
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_LOOK)
        else $error("accepted transaction did not start the lookup");

    // the scan never runs past the stored transition count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg <= n_reg)
        else $error("scan index beyond transition count");

    // a new result only ever comes out of the final step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the final step");

    // match and acceptance verdicts only come with an ok status
    a_verdict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (matched_reg || accepted_reg) |-> status_reg == ST_OK)
        else $error("verdict reported with an error status");

endmodule
